/* rtl/ecsf_pkg.sv */
// Shared types and constants of the changed-span finder.
// Used by ecsf_core, ecsf_outq and exact_changed_span_finder_top; no dependencies.
package ecsf_pkg;

	localparam int MAX_WIDTH  = 1024;
	localparam int MAX_HEIGHT = 1024;

	localparam int PIX_W   = 16;
	localparam int COL_W   = 10;
	localparam int ROW_W   = 10;
	localparam int EDGE_W  = 11;
	localparam int GAP_W   = 8;
	localparam int CNT_W   = 16;
	localparam int CIDX_W  = 2;
	localparam int CDATA_W = 16;

	localparam logic [PIX_W-1:0] COMPARE_MASK_RST  = 16'hE71C;
	localparam logic [GAP_W-1:0] GAP_THRESHOLD_RST = 8'd8;
	localparam logic [CNT_W-1:0] MAX_SPANS_RST     = 16'd10000;

	// result queue
	localparam int QUEUE_DEPTH = 4;
	localparam int QPTR_W      = 2;
	localparam int QCNT_W      = 3;

	typedef enum logic [CIDX_W-1:0] {
		CFG_COMPARE_MASK  = 2'd0,
		CFG_GAP_THRESHOLD = 2'd1,
		CFG_MAX_SPANS     = 2'd2
	} cfg_idx_t;

	typedef enum logic {
		KIND_SPAN    = 1'b0,
		KIND_SUMMARY = 1'b1
	} kind_t;

	typedef struct packed {
		logic [PIX_W-1:0] compare_mask;
		logic [GAP_W-1:0] gap_threshold;
		logic [CNT_W-1:0] max_spans;
	} cfg_t;

	typedef struct packed {
		logic [PIX_W-1:0] cur_pixel;
		logic [PIX_W-1:0] prev_pixel;
		logic             row_end;
		logic             frame_end;
	} item_t;

	typedef struct packed {
		kind_t             kind;
		logic [ROW_W-1:0]  span_row;
		logic [COL_W-1:0]  span_left;
		logic [EDGE_W-1:0] span_right;
		logic [EDGE_W-1:0] span_size;
		logic [CNT_W-1:0]  span_total;
		logic              overflowed;
		logic              last_of_run;
	} result_t;

endpackage

/* rtl/ecsf_core.sv */
// Span tracking state and per-pixel update of the changed-span finder.
// Depends on ecsf_pkg; one registered item is processed per step.
module ecsf_core (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            step,
	input  ecsf_pkg::item_t item,
	input  ecsf_pkg::cfg_t  cfg,
	output ecsf_pkg::result_t res0,
	output ecsf_pkg::result_t res1,
	output logic [1:0]      n_res
);

	logic                         span_open_q;
	logic [ecsf_pkg::COL_W-1:0]   open_left_q;
	logic [ecsf_pkg::EDGE_W-1:0]  open_right_q;
	logic [ecsf_pkg::GAP_W-1:0]   gap_count_q;
	logic [ecsf_pkg::COL_W-1:0]   column_q;
	logic [ecsf_pkg::ROW_W-1:0]   row_q;
	logic [ecsf_pkg::CNT_W-1:0]   span_count_q;
	logic                         overflow_q;

	logic                         span_open_d;
	logic [ecsf_pkg::COL_W-1:0]   open_left_d;
	logic [ecsf_pkg::EDGE_W-1:0]  open_right_d;
	logic [ecsf_pkg::GAP_W-1:0]   gap_count_d;
	logic [ecsf_pkg::COL_W-1:0]   column_d;
	logic [ecsf_pkg::ROW_W-1:0]   row_d;
	logic [ecsf_pkg::CNT_W-1:0]   span_count_d;
	logic                         overflow_d;

	logic                         changed;
	logic                         row_done;
	logic                         close;
	logic                         emit;
	logic [ecsf_pkg::CNT_W-1:0]   count_after;
	logic                         ovf_after;
	ecsf_pkg::result_t            span_rec;
	ecsf_pkg::result_t            summary;

	always_comb begin
		changed  = |((item.cur_pixel ^ item.prev_pixel) & cfg.compare_mask);
		row_done = item.row_end | item.frame_end |
			(column_q == ecsf_pkg::COL_W'(ecsf_pkg::MAX_WIDTH - 1));

		span_open_d  = span_open_q;
		open_left_d  = open_left_q;
		open_right_d = open_right_q;
		gap_count_d  = gap_count_q;
		close        = 1'b0;

		if (changed) begin
			if (!span_open_q) begin
				open_left_d = column_q;
			end
			span_open_d  = 1'b1;
			open_right_d = {1'b0, column_q} + ecsf_pkg::EDGE_W'(1);
			gap_count_d  = '0;
		end else if (span_open_q) begin
			if (gap_count_q >= cfg.gap_threshold) begin
				close = 1'b1;
			end else begin
				gap_count_d = gap_count_q + ecsf_pkg::GAP_W'(1);
			end
		end

		// at most one close per pixel: a gap close and a row end close the same span
		if (row_done && span_open_d) begin
			close = 1'b1;
		end
		if (close) begin
			span_open_d = 1'b0;
			gap_count_d = '0;
		end

		emit        = close && (span_count_q < cfg.max_spans);
		count_after = span_count_q + ecsf_pkg::CNT_W'(emit);
		ovf_after   = overflow_q | (close & ~emit);

		if (row_done) begin
			column_d = '0;
			row_d    = (row_q < ecsf_pkg::ROW_W'(ecsf_pkg::MAX_HEIGHT - 1)) ?
				row_q + ecsf_pkg::ROW_W'(1) : row_q;
		end else begin
			column_d = column_q + ecsf_pkg::COL_W'(1);
			row_d    = row_q;
		end
		span_count_d = count_after;
		overflow_d   = ovf_after;
		if (item.frame_end) begin
			row_d        = '0;
			column_d     = '0;
			span_count_d = '0;
			overflow_d   = 1'b0;
		end

		span_rec             = '0;
		span_rec.kind        = ecsf_pkg::KIND_SPAN;
		span_rec.span_row    = row_q;
		span_rec.span_left   = open_left_d;
		span_rec.span_right  = open_right_d;
		span_rec.span_size   = (open_right_d >= {1'b0, open_left_d}) ?
			open_right_d - {1'b0, open_left_d} : '0;
		span_rec.last_of_run = ~item.frame_end;

		summary             = '0;
		summary.kind        = ecsf_pkg::KIND_SUMMARY;
		summary.span_total  = count_after;
		summary.overflowed  = ovf_after;
		summary.last_of_run = 1'b1;

		res0  = emit ? span_rec : summary;
		res1  = summary;
		n_res = step ? ({1'b0, emit} + {1'b0, item.frame_end}) : 2'd0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			span_open_q  <= 1'b0;
			open_left_q  <= '0;
			open_right_q <= '0;
			gap_count_q  <= '0;
			column_q     <= '0;
			row_q        <= '0;
			span_count_q <= '0;
			overflow_q   <= 1'b0;
		end else if (step) begin
			span_open_q  <= span_open_d;
			open_left_q  <= open_left_d;
			open_right_q <= open_right_d;
			gap_count_q  <= gap_count_d;
			column_q     <= column_d;
			row_q        <= row_d;
			span_count_q <= span_count_d;
			overflow_q   <= overflow_d;
		end
	end

`ifndef SYNTHESIS
	a_close_leaves_closed: assert property (@(posedge clk) disable iff (!arst_n)
		step && close |=> !span_open_q)
		else $error("span still open after close");
	a_frame_end_clears: assert property (@(posedge clk) disable iff (!arst_n)
		step && item.frame_end |=> (span_count_q == '0) && (row_q == '0) && !overflow_q)
		else $error("frame state not cleared at frame end");
	a_row_end_closes: assert property (@(posedge clk) disable iff (!arst_n)
		step && row_done |=> !span_open_q && (column_q == '0))
		else $error("span or column survived row end");
`endif

endmodule

/* rtl/ecsf_outq.sv */
// Small result queue: takes up to two results per cycle, hands out one.
// Depends on ecsf_pkg.
module ecsf_outq (
	input  logic              clk,
	input  logic              arst_n,
	input  logic [1:0]        push_n,
	input  ecsf_pkg::result_t res0,
	input  ecsf_pkg::result_t res1,
	output logic              room,
	output logic              out_valid,
	input  logic              out_ready,
	output ecsf_pkg::result_t head
);

	ecsf_pkg::result_t              mem_q [ecsf_pkg::QUEUE_DEPTH];
	logic [ecsf_pkg::QPTR_W-1:0]    wr_ptr_q;
	logic [ecsf_pkg::QPTR_W-1:0]    rd_ptr_q;
	logic [ecsf_pkg::QCNT_W-1:0]    count_q;
	logic                           pop;

	assign out_valid = (count_q != '0);
	assign pop       = out_valid & out_ready;
	assign head      = mem_q[rd_ptr_q];
	// room for the worst case of two results from one pixel
	assign room      = (count_q <= ecsf_pkg::QCNT_W'(ecsf_pkg::QUEUE_DEPTH - 2));

	always_ff @(posedge clk) begin
		if (push_n != 2'd0) begin
			mem_q[wr_ptr_q] <= res0;
		end
		if (push_n == 2'd2) begin
			mem_q[wr_ptr_q + ecsf_pkg::QPTR_W'(1)] <= res1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			wr_ptr_q <= wr_ptr_q + ecsf_pkg::QPTR_W'(push_n);
			rd_ptr_q <= rd_ptr_q + ecsf_pkg::QPTR_W'(pop);
			count_q  <= count_q + ecsf_pkg::QCNT_W'(push_n) - ecsf_pkg::QCNT_W'(pop);
		end
	end

`ifndef SYNTHESIS
	a_no_overrun: assert property (@(posedge clk) disable iff (!arst_n)
		(push_n != 2'd0) |->
			(count_q + ecsf_pkg::QCNT_W'(push_n)) <= ecsf_pkg::QCNT_W'(ecsf_pkg::QUEUE_DEPTH))
		else $error("result queue overrun");
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= ecsf_pkg::QCNT_W'(ecsf_pkg::QUEUE_DEPTH))
		else $error("result queue count out of range");
	a_push_limit: assert property (@(posedge clk) disable iff (!arst_n)
		push_n != 2'd3)
		else $error("more than two results pushed at once");
`endif

endmodule

/* rtl/exact_changed_span_finder_top.sv */
// Top level of the changed-span finder: config registers, input stage,
// span core and result queue. Depends on ecsf_pkg, ecsf_core, ecsf_outq.
//
// Usage:
//   Input channel (in_valid/in_ready): one request per pixel in raster order,
//   carrying the current and previous RGB565 pixel plus row_end/frame_end.
//   Output channel (out_valid/out_ready): span records (kind 0) and a frame
//   summary (kind 1) after the last pixel of a frame; last_of_run marks the
//   final result caused by one pixel. A pixel yields zero, one or two results.
//   Config: cfg_we writes cfg_data into register cfg_index (0 compare_mask,
//   1 gap_threshold, 2 max_spans) at the clock edge; write only while idle.
// Timing:
//   A request is registered in the input stage at acceptance and processed by
//   the span core, once the queue has room, into a four-entry result queue;
//   its first result shows on the output once it is written to the queue.
//   One pixel per cycle is sustained while the queue has room;
//   the limit is the single queue read port when pixels produce two results.
//   When the receiver stalls, the queue fills and in_ready drops once it holds
//   more than two results; nothing is lost.
// Reset: arst_n clears span state, counters, queue and restores the config
//   registers to their defaults; no clearing pass is needed.
module exact_changed_span_finder_top (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_we,
	input  logic [ecsf_pkg::CIDX_W-1:0]   cfg_index,
	input  logic [ecsf_pkg::CDATA_W-1:0]  cfg_data,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic [ecsf_pkg::PIX_W-1:0]    cur_pixel,
	input  logic [ecsf_pkg::PIX_W-1:0]    prev_pixel,
	input  logic                          row_end,
	input  logic                          frame_end,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic                          kind,
	output logic [ecsf_pkg::ROW_W-1:0]    span_row,
	output logic [ecsf_pkg::COL_W-1:0]    span_left,
	output logic [ecsf_pkg::EDGE_W-1:0]   span_right,
	output logic [ecsf_pkg::EDGE_W-1:0]   span_size,
	output logic [ecsf_pkg::CNT_W-1:0]    span_total,
	output logic                          overflowed,
	output logic                          last_of_run
);

	ecsf_pkg::cfg_t     cfg_q;
	logic               valid_s1;
	ecsf_pkg::item_t    item_s1;
	logic               room;
	logic               advance;
	logic               accept;
	logic [1:0]         n_res;
	ecsf_pkg::result_t  res0;
	ecsf_pkg::result_t  res1;
	ecsf_pkg::result_t  head;

	// Config registers; index 3 is ignored.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.compare_mask  <= ecsf_pkg::COMPARE_MASK_RST;
			cfg_q.gap_threshold <= ecsf_pkg::GAP_THRESHOLD_RST;
			cfg_q.max_spans     <= ecsf_pkg::MAX_SPANS_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				ecsf_pkg::CFG_COMPARE_MASK: begin
					cfg_q.compare_mask <= cfg_data;
				end
				ecsf_pkg::CFG_GAP_THRESHOLD: begin
					cfg_q.gap_threshold <= cfg_data[ecsf_pkg::GAP_W-1:0];
				end
				ecsf_pkg::CFG_MAX_SPANS: begin
					cfg_q.max_spans <= cfg_data;
				end
				default: begin
				end
			endcase
		end
	end

	// Input stage: the core consumes it whenever the queue can take two results.
	assign advance  = valid_s1 & room;
	assign in_ready = ~valid_s1 | advance;
	assign accept   = in_valid & in_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			item_s1.cur_pixel  <= cur_pixel;
			item_s1.prev_pixel <= prev_pixel;
			item_s1.row_end    <= row_end;
			item_s1.frame_end  <= frame_end;
		end
	end

	ecsf_core u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.step   (advance),
		.item   (item_s1),
		.cfg    (cfg_q),
		.res0   (res0),
		.res1   (res1),
		.n_res  (n_res)
	);

	ecsf_outq u_outq (
		.clk       (clk),
		.arst_n    (arst_n),
		.push_n    (n_res),
		.res0      (res0),
		.res1      (res1),
		.room      (room),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.head      (head)
	);

	assign kind        = head.kind;
	assign span_row    = head.span_row;
	assign span_left   = head.span_left;
	assign span_right  = head.span_right;
	assign span_size   = head.span_size;
	assign span_total  = head.span_total;
	assign overflowed  = head.overflowed;
	assign last_of_run = head.last_of_run;

`ifndef SYNTHESIS
	a_stall_means_full: assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |-> valid_s1 && !room)
		else $error("input stalled without a pending pixel");
	a_no_push_without_step: assert property (@(posedge clk) disable iff (!arst_n)
		!advance |-> n_res == 2'd0)
		else $error("results pushed without a pixel");
	a_pending_held: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && !advance |=> valid_s1 && $stable(item_s1))
		else $error("pending pixel changed while stalled");
`endif

endmodule
